### rtl/spmq_pkg.sv
// ----------------------------------------------------------------------------
// Shared-pool multi-queue buffer package
// Common constants, codes and control types for the buffer modules.
// ----------------------------------------------------------------------------
package spmq_pkg;

   localparam int DEF_PARTITIONS = 8;
   localparam int DEF_BLOCKS     = 32;
   localparam int DEF_BLOCK_BITS = 32;

   localparam int LFSR_W           = 16;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;
   localparam logic [15:0] LFSR_SEED = 16'h0001;

   localparam logic [1:0] FUNC_INSERT   = 2'd0;
   localparam logic [1:0] FUNC_TAKE     = 2'd1;
   localparam logic [1:0] FUNC_TAKE_ANY = 2'd2;
   localparam logic [1:0] FUNC_STATUS   = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   localparam int MAX_KW = 7;

   typedef struct packed {
      logic              start;
      logic [LFSR_W-1:0] dividend;
      logic [MAX_KW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [MAX_KW-1:0] remainder;
   } div_rsp_type;

endpackage

### rtl/shared_pool_multi_queue_buffer.sv
// ----------------------------------------------------------------------------
// Shared-pool multi-queue buffer
// Per-partition FIFO queues of blocks drawn from one pool with a free list.
// ----------------------------------------------------------------------------
// One request is handled at a time. An insert runs dispatch, insert write and
// finish; a take runs dispatch, take read, take write and finish; a status runs
// dispatch and finish; a take-any waits for the modulo unit and scans partitions
// up to the chosen one before its take. Links sit in a registered-read RAM, so
// each insert or take reads a link and in the next state uses it and writes one.
// A pass over all blocks after reset chains the free list, taking no request.
module shared_pool_multi_queue_buffer #(
   parameter int PARTITIONS = spmq_pkg::DEF_PARTITIONS,
   parameter int BLOCKS     = spmq_pkg::DEF_BLOCKS,
   parameter int BLOCK_BITS = spmq_pkg::DEF_BLOCK_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [2:0]  req_partition,
   input  logic [31:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_served_partition,
   output logic [31:0] rsp_payload_out,
   output logic [5:0]  rsp_used_total,
   output logic [5:0]  rsp_partition_count
);
   import spmq_pkg::*;

   localparam int PW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
   localparam int KW = $clog2(PARTITIONS + 1);
   localparam int BW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int CW = $clog2(BLOCKS + 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DISP, ST_INS_WR, ST_DIV, ST_SCAN,
      ST_TAKE_RD, ST_TAKE_WR, ST_FIN
   } state_type;

   function automatic logic [PW-1:0] part_idx(input logic [2:0] v);
      logic [6:0] t;
      t = 7'(v);
      for (int j = 0; j < 8; j++) begin
         if (t >= 7'(PARTITIONS)) t = t - 7'(PARTITIONS);
      end
      return PW'(t);
   endfunction

   state_type            state_ff, state_in;
   logic [BW-1:0]        clr_ff, clr_in;
   logic [1:0]           func_ff, func_in;
   logic [PW-1:0]        part_ff, part_in;
   logic [PW-1:0]        sel_ff, sel_in;
   logic [PW-1:0]        scan_ff, scan_in;
   logic [KW-1:0]        pick_ff, pick_in;
   logic [BLOCK_BITS-1:0] pay_ff, pay_in;
   logic [BLOCK_BITS-1:0] got_ff, got_in;
   logic [1:0]           stat_ff, stat_in;
   logic [BW-1:0]        qhead_ff [PARTITIONS];
   logic [BW-1:0]        qtail_ff [PARTITIONS];
   logic [CW-1:0]        qcnt_ff  [PARTITIONS];
   logic [PARTITIONS-1:0] nonempty_ff, nonempty_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [BW-1:0]        fhead_ff, fhead_in;
   logic [BW-1:0]        ftail_ff, ftail_in;
   logic [CW-1:0]        used_ff, used_in;
   logic [LFSR_W-1:0]    lfsr_ff, lfsr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [2:0]           rsp_served_ff, rsp_served_in;
   logic [31:0]          rsp_payload_ff, rsp_payload_in;
   logic [5:0]           rsp_used_ff, rsp_used_in;
   logic [5:0]           rsp_count_ff, rsp_count_in;

   logic [PW-1:0]   idx;
   logic [BW-1:0]   cur_head, cur_tail;
   logic [CW-1:0]   cur_cnt;
   logic            q_we;
   logic [BW-1:0]   q_head_wd, q_tail_wd;
   logic [CW-1:0]   q_cnt_wd;
   logic            link_we, link_re;
   logic [BW-1:0]   link_wa, link_wd, link_ra, link_rd;
   logic            store_we, store_re;
   logic [BW-1:0]   store_ra;
   logic [BLOCK_BITS-1:0] store_rd;
   div_req_type     div_req;
   div_rsp_type     div_rsp;
   logic            rsp_free;

   assign idx      = (state_ff == ST_FIN) ? part_ff : sel_ff;
   assign cur_head = qhead_ff[idx];
   assign cur_tail = qtail_ff[idx];
   assign cur_cnt  = qcnt_ff[idx];
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      func_in        = func_ff;
      part_in        = part_ff;
      sel_in         = sel_ff;
      scan_in        = scan_ff;
      pick_in        = pick_ff;
      pay_in         = pay_ff;
      got_in         = got_ff;
      stat_in        = stat_ff;
      nonempty_in    = nonempty_ff;
      k_in           = k_ff;
      fhead_in       = fhead_ff;
      ftail_in       = ftail_ff;
      used_in        = used_ff;
      lfsr_in        = lfsr_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_served_in  = rsp_served_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_used_in    = rsp_used_ff;
      rsp_count_in   = rsp_count_ff;
      q_we           = 1'b0;
      q_head_wd      = cur_head;
      q_tail_wd      = cur_tail;
      q_cnt_wd       = cur_cnt;
      link_we        = 1'b0;
      link_wa        = clr_ff;
      link_wd        = (clr_ff == BW'(BLOCKS - 1)) ? '0 : clr_ff + 1'b1;
      link_re        = 1'b0;
      link_ra        = fhead_ff;
      store_we       = 1'b0;
      store_re       = 1'b0;
      store_ra       = cur_head;
      div_req        = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            link_we = 1'b1;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == BW'(BLOCKS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               part_in  = part_idx(req_partition);
               sel_in   = part_idx(req_partition);
               pay_in   = BLOCK_BITS'(req_payload);
               got_in   = '0;
               stat_in  = STAT_OK;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            state_in = ST_FIN;
            unique case (func_ff)
               FUNC_INSERT: begin
                  if (used_ff == CW'(BLOCKS)) begin
                     stat_in = STAT_FULL;
                  end else begin
                     link_re  = 1'b1;
                     state_in = ST_INS_WR;
                  end
               end
               FUNC_TAKE: begin
                  if (cur_cnt == '0) stat_in = STAT_EMPTY;
                  else state_in = ST_TAKE_RD;
               end
               FUNC_TAKE_ANY: begin
                  if (k_ff == '0) begin
                     stat_in = STAT_EMPTY;
                     sel_in  = '0;
                  end else begin
                     div_req.start    = 1'b1;
                     div_req.dividend = lfsr_ff;
                     div_req.divisor  = MAX_KW'(k_ff);
                     lfsr_in = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : '0);
                     state_in = ST_DIV;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_INS_WR: begin
            fhead_in  = link_rd;
            store_we  = 1'b1;
            q_we      = 1'b1;
            q_tail_wd = fhead_ff;
            q_cnt_wd  = cur_cnt + 1'b1;
            if (cur_cnt == '0) begin
               q_head_wd = fhead_ff;
               nonempty_in[sel_ff] = 1'b1;
               k_in = k_ff + 1'b1;
            end else begin
               link_we = 1'b1;
               link_wa = cur_tail;
               link_wd = fhead_ff;
            end
            used_in  = used_ff + 1'b1;
            state_in = ST_FIN;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               pick_in  = KW'(div_rsp.remainder);
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (nonempty_ff[scan_ff]) begin
               if (pick_ff == '0) begin
                  sel_in   = scan_ff;
                  state_in = ST_TAKE_RD;
               end else begin
                  pick_in = pick_ff - 1'b1;
               end
            end
         end
         ST_TAKE_RD: begin
            link_re  = 1'b1;
            link_ra  = cur_head;
            store_re = 1'b1;
            state_in = ST_TAKE_WR;
         end
         ST_TAKE_WR: begin
            got_in    = store_rd;
            q_we      = 1'b1;
            q_head_wd = link_rd;
            q_cnt_wd  = cur_cnt - 1'b1;
            if (cur_cnt == CW'(1)) begin
               nonempty_in[sel_ff] = 1'b0;
               k_in = k_ff - 1'b1;
            end
            if (used_ff == CW'(BLOCKS)) begin
               fhead_in = cur_head;
            end else begin
               link_we = 1'b1;
               link_wa = ftail_ff;
               link_wd = cur_head;
            end
            ftail_in = cur_head;
            used_in  = used_ff - 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = stat_ff;
               rsp_served_in  = 3'(sel_ff);
               rsp_payload_in = 32'(got_ff);
               rsp_used_in    = 6'(used_ff);
               rsp_count_in   = 6'(cur_cnt);
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         nonempty_ff  <= '0;
         k_ff         <= '0;
         fhead_ff     <= '0;
         ftail_ff     <= BW'(BLOCKS - 1);
         used_ff      <= '0;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PARTITIONS; i++) begin
            qhead_ff[i] <= '0;
            qtail_ff[i] <= '0;
            qcnt_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         nonempty_ff  <= nonempty_in;
         k_ff         <= k_in;
         fhead_ff     <= fhead_in;
         ftail_ff     <= ftail_in;
         used_ff      <= used_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_we) begin
            qhead_ff[idx] <= q_head_wd;
            qtail_ff[idx] <= q_tail_wd;
            qcnt_ff[idx]  <= q_cnt_wd;
         end
      end
      func_ff        <= func_in;
      part_ff        <= part_in;
      sel_ff         <= sel_in;
      scan_ff        <= scan_in;
      pick_ff        <= pick_in;
      pay_ff         <= pay_in;
      got_ff         <= got_in;
      stat_ff        <= stat_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_served_ff  <= rsp_served_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_used_ff    <= rsp_used_in;
      rsp_count_ff   <= rsp_count_in;
   end

   spmq_ram #(.WIDTH(BW), .DEPTH(BLOCKS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (link_re),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   spmq_ram #(.WIDTH(BLOCK_BITS), .DEPTH(BLOCKS)) u_store_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (fhead_ff),
      .wr_data (pay_ff),
      .rd_en   (store_re),
      .rd_addr (store_ra),
      .rd_data (store_rd)
   );

   spmq_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_served_partition = rsp_served_ff;
   assign rsp_payload_out      = rsp_payload_ff;
   assign rsp_used_total       = rsp_used_ff;
   assign rsp_partition_count  = rsp_count_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(BLOCKS))
      else $error("pool use exceeds the number of blocks");

   a_k_matches: assert property (@(posedge clock) disable iff (reset)
      32'(k_ff) == $countones(nonempty_ff))
      else $error("non-empty partition count out of step");

   a_empty_pool: assert property (@(posedge clock) disable iff (reset)
      (k_ff == '0) == (used_ff == '0))
      else $error("partition occupancy disagrees with pool use");

   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TAKE_RD |-> nonempty_ff[sel_ff])
      else $error("take started on an empty partition");

endmodule

### rtl/spmq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module spmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/spmq_mod.sv
// ----------------------------------------------------------------------------
// Shared-pool buffer modulo unit
// Restoring division giving the remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module spmq_mod (
   input  logic                  clock,
   input  logic                  reset,
   input  spmq_pkg::div_req_type req,
   output spmq_pkg::div_rsp_type rsp
);
   import spmq_pkg::*;

   localparam int SW = $clog2(LFSR_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SW-1:0]     step_ff, step_in;
   logic [LFSR_W-1:0] dvd_ff, dvd_in;
   logic [MAX_KW-1:0] dvs_ff, dvs_in;
   logic [MAX_KW:0]   rem_ff, rem_in;
   logic [MAX_KW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff[MAX_KW-1:0], dvd_ff[LFSR_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[LFSR_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
         end else begin
            rem_in = trial;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(LFSR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff[MAX_KW-1:0];

endmodule
